[rtl/core/qof_pkg.sv]
// Shared types, constants and arithmetic helpers for the quadratic outline flattener.
package qof_pkg;

   localparam int IN_W       = 16;                // width of the point coordinate ports
   localparam int Q_W        = 24;                // width of the sample coordinate ports
   localparam int COORD_BITS = 16;                // coordinate bits taken from each port
   localparam int HALF_W     = COORD_BITS + 1;    // point held in half font units
   localparam int ACC_W      = COORD_BITS + 10;   // forward-difference accumulators
   localparam int PAD_W      = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
   localparam int ARC_STEPS  = 10;
   localparam int CNT_W      = $clog2(ARC_STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_BAD,
      S_PT,
      S_CLOSE,
      S_SET1,
      S_SET2,
      S_RUN
   } state_type;

   // which end point the arc runs to, and what follows it
   typedef enum logic [1:0] {
      ARC_ON,
      ARC_MID,
      ARC_END
   } arc_phase_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_POINT_P,
      OUT_POINT_FIRST,
      OUT_ARC,
      OUT_BAD
   } out_sel_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] x;
      logic signed [HALF_W-1:0] y;
   } pt_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
   } acc_pt_type;

   typedef struct packed {
      logic          capture;
      logic          load_first;
      logic          load_anchor_p;
      logic          load_anchor_mid;
      logic          load_control_p;
      logic          setup1;
      logic          setup2;
      logic          step;
      arc_phase_type arc_phase;
      out_sel_type   out_sel;
      logic          out_last;
      logic          out_done;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

   // low COORD_BITS of the port, sign-extended, doubled into half units
   function automatic logic signed [HALF_W-1:0] to_half(input logic [IN_W-1:0] v);
      logic [PAD_W-1:0] z;
      z = PAD_W'(v);
      return $signed({z[COORD_BITS-1:0], 1'b0});
   endfunction

   // x100 as x64 + x32 + x4
   function automatic logic signed [ACC_W-1:0] scale100(input logic signed [HALF_W-1:0] v);
      logic signed [ACC_W-1:0] e;
      e = ACC_W'(v);
      return (e <<< 6) + (e <<< 5) + (e <<< 2);
   endfunction

   function automatic logic signed [Q_W-1:0] to_q(input logic signed [ACC_W-1:0] v);
      return Q_W'(v);
   endfunction

endpackage

[rtl/core/qof_dp.sv]
// Datapath: point registers, arc forward-difference engine and result register.
module qof_dp import qof_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IN_W-1:0]        req_px,
   input  logic [IN_W-1:0]        req_py,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [Q_W-1:0]  rsp_qx,
   output logic signed [Q_W-1:0]  rsp_qy,
   output logic                   rsp_run_last,
   output logic                   rsp_contour_done,
   output logic                   rsp_bad_start
);

   pt_type p_ff, p_in;
   pt_type anchor_ff, anchor_in;
   pt_type control_ff, control_in;
   pt_type first_ff, first_in;
   pt_type mid;
   pt_type b_pt;

   acc_pt_type f_ff, f_in;
   acc_pt_type d_ff, d_in;
   acc_pt_type dd_ff, dd_in;
   acc_pt_type s_ff, s_in;
   acc_pt_type dca_ff, dca_in;
   acc_pt_type f_next;

   logic signed [HALF_W:0] mid_sum_x;
   logic signed [HALF_W:0] mid_sum_y;

   logic                  valid_ff, valid_in;
   logic signed [Q_W-1:0] qx_ff, qx_in;
   logic signed [Q_W-1:0] qy_ff, qy_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;
   logic                  bad_ff, bad_in;
   logic                  emit;

   // implied on-curve point; the sum of two doubled inputs is always even
   assign mid_sum_x = (HALF_W+1)'(control_ff.x) + (HALF_W+1)'(p_ff.x);
   assign mid_sum_y = (HALF_W+1)'(control_ff.y) + (HALF_W+1)'(p_ff.y);
   assign mid.x     = mid_sum_x[HALF_W:1];
   assign mid.y     = mid_sum_y[HALF_W:1];

   always_comb begin
      case (cmd.arc_phase)
         ARC_ON:  b_pt = p_ff;
         ARC_MID: b_pt = mid;
         ARC_END: b_pt = first_ff;
         default: b_pt = p_ff;
      endcase
   end

   assign f_next.x = f_ff.x + d_ff.x;
   assign f_next.y = f_ff.y + d_ff.y;

   always_comb begin
      p_in       = p_ff;
      anchor_in  = anchor_ff;
      control_in = control_ff;
      first_in   = first_ff;
      if (cmd.capture) begin
         p_in.x = to_half(req_px);
         p_in.y = to_half(req_py);
      end
      if (cmd.load_first)      first_in   = p_ff;
      if (cmd.load_anchor_p)   anchor_in  = p_ff;
      if (cmd.load_anchor_mid) anchor_in  = mid;
      if (cmd.load_control_p)  control_in = p_ff;
   end

   // f(k) = 100a + k*20(c-a) + k^2*(a-2c+b), stepped by first and second differences
   always_comb begin
      f_in   = f_ff;
      d_in   = d_ff;
      dd_in  = dd_ff;
      s_in   = s_ff;
      dca_in = dca_ff;
      if (cmd.setup1) begin
         s_in.x   = ACC_W'(anchor_ff.x) - (ACC_W'(control_ff.x) <<< 1) + ACC_W'(b_pt.x);
         s_in.y   = ACC_W'(anchor_ff.y) - (ACC_W'(control_ff.y) <<< 1) + ACC_W'(b_pt.y);
         dca_in.x = ACC_W'(control_ff.x) - ACC_W'(anchor_ff.x);
         dca_in.y = ACC_W'(control_ff.y) - ACC_W'(anchor_ff.y);
         f_in.x   = scale100(anchor_ff.x);
         f_in.y   = scale100(anchor_ff.y);
      end
      if (cmd.setup2) begin
         d_in.x  = s_ff.x + (dca_ff.x <<< 4) + (dca_ff.x <<< 2);
         d_in.y  = s_ff.y + (dca_ff.y <<< 4) + (dca_ff.y <<< 2);
         dd_in.x = s_ff.x <<< 1;
         dd_in.y = s_ff.y <<< 1;
      end
      if (cmd.step) begin
         f_in   = f_next;
         d_in.x = d_ff.x + dd_ff.x;
         d_in.y = d_ff.y + dd_ff.y;
      end
   end

   assign emit = (cmd.out_sel != OUT_NONE);

   always_comb begin
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      last_in = last_ff;
      done_in = done_ff;
      bad_in  = bad_ff;
      if (emit) begin
         last_in = cmd.out_last;
         done_in = cmd.out_done;
         bad_in  = 1'b0;
         case (cmd.out_sel)
            OUT_POINT_P: begin
               qx_in = to_q(scale100(p_ff.x));
               qy_in = to_q(scale100(p_ff.y));
            end
            OUT_POINT_FIRST: begin
               qx_in = to_q(scale100(first_ff.x));
               qy_in = to_q(scale100(first_ff.y));
            end
            OUT_ARC: begin
               qx_in = to_q(f_next.x);
               qy_in = to_q(f_next.y);
            end
            OUT_BAD: begin
               qx_in  = '0;
               qy_in  = '0;
               bad_in = 1'b1;
            end
            default: begin
               qx_in = qx_ff;
               qy_in = qy_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (emit)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      anchor_ff  <= anchor_in;
      control_ff <= control_in;
      first_ff   <= first_in;
      f_ff       <= f_in;
      d_ff       <= d_in;
      dd_ff      <= dd_in;
      s_ff       <= s_in;
      dca_ff     <= dca_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
      bad_ff     <= bad_in;
   end

   assign sts.out_free     = !valid_ff || rsp_ready;
   assign rsp_valid        = valid_ff;
   assign rsp_qx           = qx_ff;
   assign rsp_qy           = qy_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_contour_done = done_ff;
   assign rsp_bad_start    = bad_ff;

endmodule

[rtl/core/qof_ctrl.sv]
// Controller: contour state flags and the per-item sequencing state machine.
module qof_ctrl import qof_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_on_curve,
   input  logic       req_contour_end,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type     state_ff, state_in;
   arc_phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic on_ff, on_in;
   logic end_ff, end_in;
   logic skipping_ff, skipping_in;
   logic in_contour_ff, in_contour_in;
   logic pending_ff, pending_in;
   logic accept;
   logic final_step;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign final_step = (cnt_ff == CNT_W'(ARC_STEPS));

   // next state and flag updates
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      on_in         = on_ff;
      end_in        = end_ff;
      skipping_in   = skipping_ff;
      in_contour_in = in_contour_ff;
      pending_in    = pending_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               on_in    = req_on_curve;
               end_in   = req_contour_end;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (skipping_ff) begin
               if (end_ff) skipping_in = 1'b0;
               state_in = S_IDLE;
            end else if (!in_contour_ff) begin
               pending_in = 1'b0;
               if (!on_ff) begin
                  skipping_in = !end_ff;
                  state_in    = S_BAD;
               end else begin
                  in_contour_in = !end_ff;
                  state_in      = S_PT;
               end
            end else if (on_ff) begin
               pending_in    = 1'b0;
               in_contour_in = !end_ff;
               if (pending_ff) begin
                  phase_in = ARC_ON;
                  state_in = S_SET1;
               end else begin
                  state_in = S_PT;
               end
            end else begin
               pending_in    = !end_ff;
               in_contour_in = !end_ff;
               if (pending_ff) begin
                  phase_in = ARC_MID;
                  state_in = S_SET1;
               end else if (end_ff) begin
                  phase_in = ARC_END;
                  state_in = S_SET1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BAD: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_PT: begin
            if (sts.out_free) state_in = end_ff ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_SET1: begin
            state_in = S_SET2;
         end
         S_SET2: begin
            cnt_in   = CNT_W'(1);
            state_in = S_RUN;
         end
         S_RUN: begin
            if (sts.out_free) begin
               if (final_step) begin
                  case (phase_ff)
                     ARC_ON:  state_in = end_ff ? S_CLOSE : S_IDLE;
                     ARC_MID: begin
                        // a closing control point follows the midpoint arc
                        if (end_ff) begin
                           phase_in = ARC_END;
                           state_in = S_SET1;
                        end else begin
                           state_in = S_IDLE;
                        end
                     end
                     ARC_END: state_in = S_IDLE;
                     default: state_in = S_IDLE;
                  endcase
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.arc_phase = phase_ff;
      cmd.out_sel   = OUT_NONE;
      case (state_ff)
         S_DECODE: begin
            if (!skipping_ff && on_ff) begin
               cmd.load_first    = !in_contour_ff;
               cmd.load_anchor_p = !in_contour_ff || !pending_ff;
            end
            if (!skipping_ff && in_contour_ff && !on_ff && !pending_ff)
               cmd.load_control_p = 1'b1;
         end
         S_BAD: begin
            if (sts.out_free) begin
               cmd.out_sel  = OUT_BAD;
               cmd.out_last = 1'b1;
            end
         end
         S_PT: begin
            if (sts.out_free) begin
               cmd.out_sel  = OUT_POINT_P;
               cmd.out_last = !end_ff;
            end
         end
         S_CLOSE: begin
            if (sts.out_free) begin
               cmd.out_sel  = OUT_POINT_FIRST;
               cmd.out_last = 1'b1;
               cmd.out_done = 1'b1;
            end
         end
         S_SET1: cmd.setup1 = 1'b1;
         S_SET2: cmd.setup2 = 1'b1;
         S_RUN: begin
            if (sts.out_free) begin
               cmd.step    = 1'b1;
               cmd.out_sel = OUT_ARC;
               if (final_step) begin
                  case (phase_ff)
                     ARC_ON: begin
                        cmd.out_last      = !end_ff;
                        cmd.load_anchor_p = 1'b1;
                     end
                     ARC_MID: begin
                        cmd.out_last        = !end_ff;
                        cmd.load_anchor_mid = 1'b1;
                        cmd.load_control_p  = 1'b1;
                     end
                     ARC_END: begin
                        cmd.out_last = 1'b1;
                        cmd.out_done = 1'b1;
                     end
                     default: cmd.out_last = 1'b0;
                  endcase
               end
            end
         end
         default: cmd.out_sel = OUT_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= ARC_ON;
         cnt_ff        <= '0;
         on_ff         <= 1'b0;
         end_ff        <= 1'b0;
         skipping_ff   <= 1'b0;
         in_contour_ff <= 1'b0;
         pending_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         on_ff         <= on_in;
         end_ff        <= end_in;
         skipping_ff   <= skipping_in;
         in_contour_ff <= in_contour_in;
         pending_ff    <= pending_in;
      end
   end

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel != OUT_NONE) |-> sts.out_free)
      else $error("result issued while output register occupied");

   a_skip_outside_contour: assert property (@(posedge clock) disable iff (reset)
      !(skipping_ff && in_contour_ff))
      else $error("skipping inside an open contour");

   a_pending_in_contour: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> in_contour_ff)
      else $error("control point held outside a contour");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (cnt_ff != '0 && cnt_ff <= CNT_W'(ARC_STEPS)))
      else $error("arc step count out of range");

endmodule

[rtl/core/quadratic_outline_flattener.sv]
// Top level of the quadratic outline flattener: controller and datapath.
//
//   channel  | ports                                         | dir | role
//   ---------+-----------------------------------------------+-----+---------------------------
//   req      | req_valid/ready, px, py, on_curve, contour_end| in  | one outline point per item
//   rsp      | rsp_valid/ready, qx, qy, run_last,            | out | one polyline vertex per item
//            | contour_done, bad_start                       |     |
//
// Items are handled one at a time. A point's result is registered after decode; a
// quadratic arc passes decode, setup states S_SET1 and S_SET2, then one sample a cycle
// from the forward-difference unit while rsp is not stalled; a closing control point
// after a held one runs two arcs. Reset is synchronous and clears all contour state.
// A stalled rsp holds the sequencer at the current sample; req_ready is low meanwhile.
module quadratic_outline_flattener import qof_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IN_W-1:0] req_px,
   input  logic signed [IN_W-1:0] req_py,
   input  logic                   req_on_curve,
   input  logic                   req_contour_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [Q_W-1:0]  rsp_qx,
   output logic signed [Q_W-1:0]  rsp_qy,
   output logic                   rsp_run_last,
   output logic                   rsp_contour_done,
   output logic                   rsp_bad_start
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   qof_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_on_curve    (req_on_curve),
      .req_contour_end (req_contour_end),
      .sts             (sts),
      .cmd             (cmd)
   );

   qof_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_px           (req_px),
      .req_py           (req_py),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_qx           (rsp_qx),
      .rsp_qy           (rsp_qy),
      .rsp_run_last     (rsp_run_last),
      .rsp_contour_done (rsp_contour_done),
      .rsp_bad_start    (rsp_bad_start)
   );

endmodule

[test/quadratic_outline_flattener_tb.sv]
// Self-checking testbench for the quadratic outline flattener: scoreboard class and top module.
module quadratic_outline_flattener_tb import qof_pkg::*; ();

   typedef struct {
      logic [Q_W-1:0] qx;
      logic [Q_W-1:0] qy;
      logic           run_last;
      logic           contour_done;
      logic           bad_start;
   } vertex_type;

   class vertex_scoreboard;
      // predicted contour state, points in half font units
      longint     anchor_x, anchor_y;
      longint     ctrl_x, ctrl_y;
      longint     first_x, first_y;
      bit         ctrl_held, open, skip;
      vertex_type due[$];
      int         errors, checked, points, contours, bad_starts, arcs, mid_arcs;

      function new();
         anchor_x = 0; anchor_y = 0; ctrl_x = 0; ctrl_y = 0; first_x = 0; first_y = 0;
         ctrl_held = 0; open = 0; skip = 0;
         errors = 0; checked = 0; points = 0; contours = 0;
         bad_starts = 0; arcs = 0; mid_arcs = 0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      // low COORD_BITS of the port, sign-extended
      function longint to_coord(logic [IN_W-1:0] raw);
         longint v;
         v = longint'(raw) & ((longint'(1) << COORD_BITS) - 1);
         if (v >= (longint'(1) << (COORD_BITS - 1)))
            v -= longint'(1) << COORD_BITS;
         return v;
      endfunction

      function void push_vertex(longint x, longint y, bit done, bit bad);
         vertex_type v;
         v.qx           = x[Q_W-1:0];
         v.qy           = y[Q_W-1:0];
         v.run_last     = 1'b0;
         v.contour_done = done;
         v.bad_start    = bad;
         due.insert(due.size(), v);
      endfunction

      function void push_arc(longint ax, longint ay, longint cx, longint cy,
                             longint bx, longint by, bit done);
         longint w0, w1, w2;
         arcs++;
         for (int k = 1; k <= ARC_STEPS; k++) begin
            w0 = (ARC_STEPS - k) * (ARC_STEPS - k);
            w1 = 2 * k * (ARC_STEPS - k);
            w2 = k * k;
            push_vertex(w0 * ax + w1 * cx + w2 * bx, w0 * ay + w1 * cy + w2 * by,
                        done && k == ARC_STEPS, 1'b0);
         end
      endfunction

      function void note_point(logic [IN_W-1:0] px, logic [IN_W-1:0] py, bit on,
                               bit last_pt);
         longint x, y, mx, my;
         int     start;
         x = 2 * to_coord(px);
         y = 2 * to_coord(py);
         start = due.size();
         points++;
         if (skip) begin
            if (last_pt)
               skip = 0;
            return;
         end
         if (!open) begin
            ctrl_held = 0;
            if (!on) begin
               push_vertex(0, 0, 1'b0, 1'b1);
               bad_starts++;
               skip = !last_pt;
            end else begin
               first_x = x; first_y = y;
               anchor_x = x; anchor_y = y;
               push_vertex(x * 100, y * 100, 1'b0, 1'b0);
               if (last_pt) begin
                  push_vertex(first_x * 100, first_y * 100, 1'b1, 1'b0);
                  contours++;
               end else
                  open = 1;
            end
         end else if (on) begin
            if (ctrl_held)
               push_arc(anchor_x, anchor_y, ctrl_x, ctrl_y, x, y, 1'b0);
            else
               push_vertex(x * 100, y * 100, 1'b0, 1'b0);
            ctrl_held = 0;
            anchor_x = x; anchor_y = y;
            if (last_pt) begin
               push_vertex(first_x * 100, first_y * 100, 1'b1, 1'b0);
               open = 0;
               contours++;
            end
         end else begin
            if (ctrl_held) begin
               // implied on-curve midpoint between two control points
               mx = (ctrl_x + x) / 2;
               my = (ctrl_y + y) / 2;
               push_arc(anchor_x, anchor_y, ctrl_x, ctrl_y, mx, my, 1'b0);
               mid_arcs++;
               anchor_x = mx; anchor_y = my;
            end
            ctrl_x = x; ctrl_y = y;
            ctrl_held = 1;
            if (last_pt) begin
               push_arc(anchor_x, anchor_y, ctrl_x, ctrl_y, first_x, first_y, 1'b1);
               ctrl_held = 0;
               open = 0;
               contours++;
            end
         end
         if (due.size() > start)
            due[due.size() - 1].run_last = 1'b1;
      endfunction

      function void compare_field(string what, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, $signed(want),
                     $signed(got));
         end
      endfunction

      function void check_vertex(logic [Q_W-1:0] qx, logic [Q_W-1:0] qy,
                                 logic rl, logic cd, logic bs);
         vertex_type want;
         checked++;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: vertex with nothing expected, qx %0d qy %0d", $time,
                     $signed(qx), $signed(qy));
            return;
         end
         want = due.pop_front();
         compare_field("qx", want.qx, qx);
         compare_field("qy", want.qy, qy);
         compare_field("run_last", Q_W'(want.run_last), Q_W'(rl));
         compare_field("contour_done", Q_W'(want.contour_done), Q_W'(cd));
         compare_field("bad_start", Q_W'(want.bad_start), Q_W'(bs));
      endfunction
   endclass

   typedef enum int {RX_OPEN, RX_RANDOM, RX_RUNS} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic signed [IN_W-1:0] req_px = '0;
   logic signed [IN_W-1:0] req_py = '0;
   logic                   req_on_curve = 1'b0;
   logic                   req_contour_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [Q_W-1:0]  rsp_qx;
   logic signed [Q_W-1:0]  rsp_qy;
   logic                   rsp_run_last;
   logic                   rsp_contour_done;
   logic                   rsp_bad_start;

   vertex_scoreboard sb;
   int  burst_left = 0;
   bit  hold_off_req = 0;

   quadratic_outline_flattener dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_on_curve     (req_on_curve),
      .req_contour_end  (req_contour_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_qx           (rsp_qx),
      .rsp_qy           (rsp_qy),
      .rsp_run_last     (rsp_run_last),
      .rsp_contour_done (rsp_contour_done),
      .rsp_bad_start    (rsp_bad_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [IN_W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return IN_W'($urandom_range(0, 40)) - IN_W'(20);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         2, 3: return IN_W'($urandom_range(0, 8192)) - IN_W'(4096);
         default: return IN_W'($urandom());
      endcase
   endfunction

   // offer one point; the sender may idle between bursts of random length
   task automatic send_point(logic [IN_W-1:0] px, logic [IN_W-1:0] py, bit on, bit last_pt);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_px          <= px;
      req_py          <= py;
      req_on_curve    <= on;
      req_contour_end <= last_pt;
      do @(posedge clock); while (!req_ready);
      sb.note_point(px, py, on, last_pt);
   endtask

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      rx_mode_type mode;
      int  mode_left, run_left, hold_left;
      bit  level;
      mode = RX_OPEN; mode_left = 0; run_left = 0; hold_left = 0; level = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 7);
               default: begin
                  if (run_left == 0) begin
                     level    = ~level;
                     run_left = $urandom_range(1, 7);
                  end
                  run_left--;
                  rsp_ready <= level;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_vertex(rsp_qx, rsp_qy, rsp_run_last, rsp_contour_done, rsp_bad_start);
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d vertices still outstanding", sb.pending());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int  rand_items, len;
      bit  bad, hold_done;
      sb = new();
      rand_items = 0;
      hold_done  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // single-point contour at the coordinate extremes
      send_point(16'h7FFF, 16'h8000, 1'b1, 1'b1);
      // bad start that also ends its contour
      send_point(16'h1234, 16'hEDCB, 1'b0, 1'b1);
      // bad start, then skipped points up to the contour end
      send_point(16'h8000, 16'h7FFF, 1'b0, 1'b0);
      send_point(16'h0001, 16'h0002, 1'b1, 1'b0);
      send_point(16'h0003, 16'h0004, 1'b0, 1'b0);
      send_point(16'h0005, 16'h0006, 1'b1, 1'b1);
      // lines, an arc, an implied midpoint, closing on an on-curve point
      send_point(16'h8000, 16'h8000, 1'b1, 1'b0);
      send_point(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
      send_point(16'h0064, 16'hFF38, 1'b0, 1'b0);
      send_point(16'h0005, 16'h0005, 1'b1, 1'b0);
      send_point(16'h8000, 16'h7FFF, 1'b0, 1'b0);
      send_point(16'h7FFF, 16'h8000, 1'b0, 1'b0);
      send_point(16'hFFFF, 16'h0000, 1'b1, 1'b1);
      // closing on a control point after a held one: thirty-one vertices
      send_point(16'h0001, 16'h0001, 1'b1, 1'b0);
      send_point(16'h0002, 16'h0003, 1'b0, 1'b0);
      send_point(16'hFFFD, 16'hFFF9, 1'b0, 1'b0);
      send_point(16'h7FFF, 16'h8000, 1'b0, 1'b1);
      // plain closing arc
      send_point(16'h0000, 16'h0000, 1'b1, 1'b0);
      send_point(16'h8000, 16'h8000, 1'b0, 1'b1);
      // last point equal to the first, closing vertex still repeated
      send_point(16'h0010, 16'hFFF0, 1'b1, 1'b0);
      send_point(16'h0010, 16'hFFF0, 1'b1, 1'b1);

      while (rand_items < 330) begin
         if (rand_items >= 120 && !hold_done) begin
            hold_off_req = 1;
            hold_done    = 1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_point(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            rand_items++;
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            bad = ($urandom_range(0, 11) == 0);
            for (int i = 0; i < len; i++)
               send_point(pick_coord(), pick_coord(),
                          (i == 0) ? !bad : ($urandom_range(0, 9) < 5), i == len - 1);
            rand_items += len;
         end
      end

      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d points: %0d contours closed, %0d bad starts, %0d arcs, %0d via midpoints",
               sb.points, sb.contours, sb.bad_starts, sb.arcs, sb.mid_arcs);
      $display("%0d vertices checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
